[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset
`define VNA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset
`define VNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/vna_pkg.sv]
`default_nettype none
package vna_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = 13;
  localparam int IDX_W        = 12;
  localparam int COORD_W      = 24;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int CROSS_W      = PROD_W + 1;
  localparam int SUM_W        = 64;
  localparam int RED_W        = 31;
  localparam int SQ_W         = 2 * RED_W;
  localparam int LEN_W        = 32;
  localparam int FRAC_W       = 15;
  localparam int NUM_W        = RED_W + FRAC_W + 1;
  localparam int QUOT_W       = 17;
  localparam int NORM_W       = 16;
  localparam int STEP_W       = 6;
  localparam int SQRT_STEPS   = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_TRI   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_BAD_INDEX = 2'd2,
    STS_ZERO      = 2'd3
  } sts_t;

  typedef enum logic [4:0] {
    S_IDLE, S_VRD, S_DIFF, S_MUL1, S_MUL2, S_CROSS, S_ARD, S_AWR,
    S_QRD, S_QMAG, S_NORM, S_SQ, S_SSUM, S_SQRT, S_DIVI, S_DIV, S_DONE
  } state_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [IDX_W-1:0]          corner_a;
    logic [IDX_W-1:0]          corner_b;
    logic [IDX_W-1:0]          corner_c;
    logic [IDX_W-1:0]          query_index;
  } in_word_t;

  typedef struct packed {
    sts_t                     status;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic [CNT_W-1:0]         vertex_count;
  } out_word_t;

endpackage
`default_nettype wire

[rtl/vertex_normal_accumulator_unit.sv]
`default_nettype none
// Clear, load and rejected words: result strobed in the cycle after start.
// Add triangle: three vertex reads, cross product, then three read-modify-writes
//   on the accumulator memory, one per corner.
// Read normal: 1-bit normalize shifts (up to 33), 32-step root, 17-step divide;
//   a zero-length normal ends after the normalize check. Next start is taken with the strobe.
// Sync active-low reset empties the store; each load zeroes its entry. No result stall.
`include "assert_macros.svh"
module vertex_normal_accumulator_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire vna_pkg::in_word_t  in_word,
  output logic                    out_valid,
  output vna_pkg::out_word_t      out_word
);
  import vna_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
  } sum_t;

  // Memories
  vtx_t vmem [MAX_VERTICES];
  sum_t smem [MAX_VERTICES];
  vtx_t vmem_q_r;
  sum_t smem_q_r;
  logic              vmem_we, smem_we;
  logic [ADDR_W-1:0] vmem_raddr, smem_raddr, smem_waddr;
  sum_t              smem_wdata;

  // Control registers
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  // Datapath registers
  logic [IDX_W-1:0]           cor_r [3];
  logic [IDX_W-1:0]           cor_nxt [3];
  vtx_t                       vert_r [3];
  vtx_t                       vert_nxt [3];
  logic signed [DIFF_W-1:0]   p_r [3], q_r [3], p_nxt [3], q_nxt [3];
  logic signed [PROD_W-1:0]   pa_r [3], pb_r [3], pa_nxt [3], pb_nxt [3];
  logic signed [CROSS_W-1:0]  cross_r [3], cross_nxt [3];
  logic                       sgn_r [3], sgn_nxt [3];
  logic [SUM_W-1:0]           mag_r [3], mag_nxt [3];
  logic [SQ_W-1:0]            sq_r [3], sq_nxt [3];
  logic [SUM_W-1:0]           n_r, n_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [LEN_W-1:0]           len_r, len_nxt;
  logic [LEN_W-1:0]           rem_r [3], rem_nxt [3];
  logic [QUOT_W-1:0]          low_r [3], low_nxt [3];
  logic [QUOT_W-1:0]          quot_r [3], quot_nxt [3];

  // Shared decode
  logic             accept, full, tri_bad, qry_bad;
  logic [IDX_W-1:0] cor_sel;
  logic [SUM_W-1:0] mmax;
  logic [SUM_W-1:0] sq_sum;

  assign accept  = start && !busy;
  assign full    = (count_r == CNT_W'(MAX_VERTICES));
  assign tri_bad = ({1'b0, in_word.corner_a} >= count_r) ||
                   ({1'b0, in_word.corner_b} >= count_r) ||
                   ({1'b0, in_word.corner_c} >= count_r);
  assign qry_bad = ({1'b0, in_word.query_index} >= count_r);

  // Pick the corner for the current step
  always_comb begin
    case (step_r[1:0])
      2'd1:    cor_sel = cor_r[1];
      2'd2:    cor_sel = cor_r[2];
      default: cor_sel = cor_r[0];
    endcase
  end

  // Largest magnitude for the normalize shift
  always_comb begin
    mmax = mag_r[0];
    if (mag_r[1] > mmax) mmax = mag_r[1];
    if (mag_r[2] > mmax) mmax = mag_r[2];
  end

  assign sq_sum = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]   a,
    input logic signed [CROSS_W-1:0] c
  );
    logic signed [SUM_W-1:0] b;
    logic signed [SUM_W-1:0] s;
    b = SUM_W'(c);
    s = a + b;
    if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1]))
      s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    return s;
  endfunction

  // Clamp the quotient to 32767 before applying the sign
  function automatic logic signed [NORM_W-1:0] to_q15(
    input logic [QUOT_W-1:0] q,
    input logic              neg
  );
    logic [NORM_W-1:0] m;
    m = (q[QUOT_W-1:NORM_W-1] != '0) ? {1'b0, {(NORM_W-1){1'b1}}} : q[NORM_W-1:0];
    return neg ? -m : m;
  endfunction

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_word.cmd == CMD_TRI && !tri_bad)       state_nxt = S_VRD;
          else if (in_word.cmd == CMD_READ && !qry_bad) state_nxt = S_QRD;
        end
      end
      S_VRD:   if (step_r == STEP_W'(3)) state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_CROSS;
      S_CROSS: state_nxt = S_ARD;
      S_ARD:   state_nxt = S_AWR;
      S_AWR:   state_nxt = (step_r == STEP_W'(2)) ? S_IDLE : S_ARD;
      S_QRD:   state_nxt = S_QMAG;
      S_QMAG:  state_nxt = S_NORM;
      S_NORM: begin
        if (mmax == '0)
          state_nxt = S_IDLE;
        else if (mmax[SUM_W-1:RED_W] == '0 && mmax[RED_W-1])
          state_nxt = S_SQ;
      end
      S_SQ:    state_nxt = S_SSUM;
      S_SSUM:  state_nxt = S_SQRT;
      S_SQRT:  if (step_r == STEP_W'(SQRT_STEPS - 1)) state_nxt = S_DIVI;
      S_DIVI:  state_nxt = S_DIV;
      S_DIV:   if (step_r == STEP_W'(QUOT_W - 1)) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    logic [SUM_W-1:0]  rb;
    logic [NUM_W-1:0]  num;
    logic [LEN_W:0]    t;
    logic              ge;
    sum_t              acc;

    count_nxt     = count_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    vmem_we       = 1'b0;
    smem_we       = 1'b0;
    vmem_raddr    = cor_sel;
    smem_raddr    = cor_sel;
    smem_waddr    = cor_sel;
    smem_wdata    = '0;
    n_nxt         = n_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    len_nxt       = len_r;
    rb            = '0;
    num           = '0;
    t             = '0;
    ge            = 1'b0;
    acc           = '0;
    for (int k = 0; k < 3; k++) begin
      cor_nxt[k]   = cor_r[k];
      vert_nxt[k]  = vert_r[k];
      p_nxt[k]     = p_r[k];
      q_nxt[k]     = q_r[k];
      pa_nxt[k]    = pa_r[k];
      pb_nxt[k]    = pb_r[k];
      cross_nxt[k] = cross_r[k];
      sgn_nxt[k]   = sgn_r[k];
      mag_nxt[k]   = mag_r[k];
      sq_nxt[k]    = sq_r[k];
      rem_nxt[k]   = rem_r[k];
      low_nxt[k]   = low_r[k];
      quot_nxt[k]  = quot_r[k];
    end

    case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        out_word_nxt.normal_x = '0;
        out_word_nxt.normal_y = '0;
        out_word_nxt.normal_z = '0;
        out_word_nxt.status   = STS_OK;
        cor_nxt[0] = (in_word.cmd == CMD_READ) ? in_word.query_index : in_word.corner_a;
        cor_nxt[1] = in_word.corner_b;
        cor_nxt[2] = in_word.corner_c;
        smem_waddr = count_r[ADDR_W-1:0];
        if (accept) begin
          unique case (in_word.cmd)
            CMD_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            CMD_LOAD: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_word_nxt.status = STS_FULL;
              end else begin
                vmem_we   = 1'b1;
                smem_we   = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_TRI: begin
              if (tri_bad) begin
                out_word_nxt.status = STS_BAD_INDEX;
                out_valid_nxt       = 1'b1;
              end
            end
            CMD_READ: begin
              if (qry_bad) begin
                out_word_nxt.status = STS_BAD_INDEX;
                out_valid_nxt       = 1'b1;
              end
            end
            default: ;
          endcase
        end
        out_word_nxt.vertex_count = count_nxt;
      end
      // Issue corner reads, capture each the cycle after
      S_VRD: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r != '0) vert_nxt[step_r[1:0] - 2'd1] = vmem_q_r;
      end
      S_DIFF: begin
        p_nxt[0] = DIFF_W'(vert_r[2].x) - DIFF_W'(vert_r[0].x);
        p_nxt[1] = DIFF_W'(vert_r[2].y) - DIFF_W'(vert_r[0].y);
        p_nxt[2] = DIFF_W'(vert_r[2].z) - DIFF_W'(vert_r[0].z);
        q_nxt[0] = DIFF_W'(vert_r[1].x) - DIFF_W'(vert_r[0].x);
        q_nxt[1] = DIFF_W'(vert_r[1].y) - DIFF_W'(vert_r[0].y);
        q_nxt[2] = DIFF_W'(vert_r[1].z) - DIFF_W'(vert_r[0].z);
      end
      S_MUL1: begin
        pa_nxt[0] = p_r[1] * q_r[2];
        pa_nxt[1] = p_r[2] * q_r[0];
        pa_nxt[2] = p_r[0] * q_r[1];
      end
      S_MUL2: begin
        pb_nxt[0] = p_r[2] * q_r[1];
        pb_nxt[1] = p_r[0] * q_r[2];
        pb_nxt[2] = p_r[1] * q_r[0];
      end
      S_CROSS: begin
        step_nxt = '0;
        for (int k = 0; k < 3; k++)
          cross_nxt[k] = CROSS_W'(pa_r[k]) - CROSS_W'(pb_r[k]);
      end
      S_ARD: ;
      // Saturating add, write back; next corner reads after this write lands
      S_AWR: begin
        acc.x      = sat_add(smem_q_r.x, cross_r[0]);
        acc.y      = sat_add(smem_q_r.y, cross_r[1]);
        acc.z      = sat_add(smem_q_r.z, cross_r[2]);
        smem_wdata = acc;
        smem_we    = 1'b1;
        step_nxt   = step_r + STEP_W'(1);
        if (step_r == STEP_W'(2)) out_valid_nxt = 1'b1;
      end
      S_QRD: ;
      S_QMAG: begin
        sgn_nxt[0] = smem_q_r.x[SUM_W-1];
        sgn_nxt[1] = smem_q_r.y[SUM_W-1];
        sgn_nxt[2] = smem_q_r.z[SUM_W-1];
        mag_nxt[0] = smem_q_r.x[SUM_W-1] ? -smem_q_r.x : smem_q_r.x;
        mag_nxt[1] = smem_q_r.y[SUM_W-1] ? -smem_q_r.y : smem_q_r.y;
        mag_nxt[2] = smem_q_r.z[SUM_W-1] ? -smem_q_r.z : smem_q_r.z;
      end
      // Shift one bit a cycle until the largest sits in [2^30, 2^31)
      S_NORM: begin
        if (mmax == '0) begin
          out_word_nxt.status = STS_ZERO;
          out_valid_nxt       = 1'b1;
        end else if (mmax[SUM_W-1:RED_W] != '0) begin
          for (int k = 0; k < 3; k++) mag_nxt[k] = mag_r[k] >> 1;
        end else if (!mmax[RED_W-1]) begin
          for (int k = 0; k < 3; k++) mag_nxt[k] = mag_r[k] << 1;
        end
      end
      S_SQ: begin
        for (int k = 0; k < 3; k++) sq_nxt[k] = mag_r[k][RED_W-1:0] * mag_r[k][RED_W-1:0];
      end
      S_SSUM: begin
        n_nxt    = sq_sum;
        res_nxt  = '0;
        bit_nxt  = SUM_W'(1) << (SUM_W - 2);
        step_nxt = '0;
      end
      // Integer square root, one result bit a cycle
      S_SQRT: begin
        rb = res_r + bit_r;
        if (n_r >= rb) begin
          n_nxt   = n_r - rb;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        step_nxt = step_r + STEP_W'(1);
      end
      // Load rounded dividends; top bits already below the divisor
      S_DIVI: begin
        len_nxt  = res_r[LEN_W-1:0];
        step_nxt = '0;
        for (int k = 0; k < 3; k++) begin
          num         = {mag_r[k][RED_W-1:0], {FRAC_W{1'b0}}} + NUM_W'(res_r[LEN_W-1:1]);
          rem_nxt[k]  = LEN_W'(num[NUM_W-1:QUOT_W]);
          low_nxt[k]  = num[QUOT_W-1:0];
          quot_nxt[k] = '0;
        end
      end
      // Restoring divide, three lanes in step
      S_DIV: begin
        for (int k = 0; k < 3; k++) begin
          t           = {rem_r[k], low_r[k][QUOT_W-1]};
          ge          = (t >= {1'b0, len_r});
          rem_nxt[k]  = ge ? LEN_W'(t - {1'b0, len_r}) : t[LEN_W-1:0];
          low_nxt[k]  = low_r[k] << 1;
          quot_nxt[k] = {quot_r[k][QUOT_W-2:0], ge};
        end
        step_nxt = step_r + STEP_W'(1);
      end
      S_DONE: begin
        out_word_nxt.normal_x = to_q15(quot_r[0], sgn_r[0]);
        out_word_nxt.normal_y = to_q15(quot_r[1], sgn_r[1]);
        out_word_nxt.normal_z = to_q15(quot_r[2], sgn_r[2]);
        out_valid_nxt         = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    n_r        <= n_nxt;
    res_r      <= res_nxt;
    bit_r      <= bit_nxt;
    len_r      <= len_nxt;
    for (int k = 0; k < 3; k++) begin
      cor_r[k]   <= cor_nxt[k];
      vert_r[k]  <= vert_nxt[k];
      p_r[k]     <= p_nxt[k];
      q_r[k]     <= q_nxt[k];
      pa_r[k]    <= pa_nxt[k];
      pb_r[k]    <= pb_nxt[k];
      cross_r[k] <= cross_nxt[k];
      sgn_r[k]   <= sgn_nxt[k];
      mag_r[k]   <= mag_nxt[k];
      sq_r[k]    <= sq_nxt[k];
      rem_r[k]   <= rem_nxt[k];
      low_r[k]   <= low_nxt[k];
      quot_r[k]  <= quot_nxt[k];
    end
  end

  // Vertex memory
  always_ff @(posedge clk) begin
    if (vmem_we)
      vmem[count_r[ADDR_W-1:0]] <= '{x: in_word.coord_x, y: in_word.coord_y, z: in_word.coord_z};
    vmem_q_r <= vmem[vmem_raddr];
  end

  // Accumulator memory
  always_ff @(posedge clk) begin
    if (smem_we) smem[smem_waddr] <= smem_wdata;
    smem_q_r <= smem[smem_raddr];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `VNA_ASSERT_NEXT(a_accept_progress, accept, busy || out_valid, "accepted word stalled")
  `VNA_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result strobe while busy")
  `VNA_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_VERTICES), "vertex count overflow")
  `VNA_ASSERT_IMP(a_len_norm, state_r == S_DIV, len_r[LEN_W-1:LEN_W-2] != 2'b00, "root not normalized")

endmodule
`default_nettype wire

[tb/vertex_normal_accumulator_unit_tb.sv]
`default_nettype none
module vertex_normal_accumulator_unit_tb;
  import vna_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;

  vertex_normal_accumulator_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mesh mirror used for prediction
  longint    vert_x [MAX_VERTICES];
  longint    vert_y [MAX_VERTICES];
  longint    vert_z [MAX_VERTICES];
  longint    acc_x  [MAX_VERTICES];
  longint    acc_y  [MAX_VERTICES];
  longint    acc_z  [MAX_VERTICES];
  int        mesh_count = 0;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        idle_pct = 29;
  int        gen_count = 0;
  bit        taken = 1'b0;
  int        words_sent = 0;
  int        words_checked = 0;
  int        n_fail = 0;
  int        n_read_ok = 0;
  int        n_zero = 0;
  int        n_bad = 0;
  int        n_full = 0;
  int        quiet_cycles = 0;

  function automatic longint clamp_add(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? 64'sh8000000000000000
                                                       : 64'sh7fffffffffffffff;
    return s;
  endfunction

  function automatic logic signed [NORM_W-1:0] unit_q15(bit [63:0] r, bit [63:0] len,
                                                       bit neg);
    bit [63:0] q;
    q = (r * 64'd32768 + (len >> 1)) / len;
    if (q > 64'd32767) q = 64'd32767;
    if (neg) q = -q;
    return q[NORM_W-1:0];
  endfunction

  // Compute the result word for one command and update the mirror
  function automatic out_word_t predict_normal(in_word_t w);
    out_word_t res;
    longint    px, py, pz, qx, qy, qz, cx, cy, cz, sx, sy, sz;
    bit [63:0] mx, my, mz, mm, sq, root, bitv;
    int        ci [3];
    res = '0;
    res.status = STS_OK;
    case (w.cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
          acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
        end
        mesh_count = 0;
      end
      CMD_LOAD: begin
        if (mesh_count >= MAX_VERTICES) res.status = STS_FULL;
        else begin
          vert_x[mesh_count] = longint'(w.coord_x);
          vert_y[mesh_count] = longint'(w.coord_y);
          vert_z[mesh_count] = longint'(w.coord_z);
          mesh_count++;
        end
      end
      CMD_TRI: begin
        ci[0] = w.corner_a; ci[1] = w.corner_b; ci[2] = w.corner_c;
        if (ci[0] >= mesh_count || ci[1] >= mesh_count || ci[2] >= mesh_count)
          res.status = STS_BAD_INDEX;
        else begin
          px = vert_x[ci[2]] - vert_x[ci[0]];
          py = vert_y[ci[2]] - vert_y[ci[0]];
          pz = vert_z[ci[2]] - vert_z[ci[0]];
          qx = vert_x[ci[1]] - vert_x[ci[0]];
          qy = vert_y[ci[1]] - vert_y[ci[0]];
          qz = vert_z[ci[1]] - vert_z[ci[0]];
          cx = py * qz - pz * qy;
          cy = pz * qx - px * qz;
          cz = px * qy - py * qx;
          foreach (ci[k]) begin
            acc_x[ci[k]] = clamp_add(acc_x[ci[k]], cx);
            acc_y[ci[k]] = clamp_add(acc_y[ci[k]], cy);
            acc_z[ci[k]] = clamp_add(acc_z[ci[k]], cz);
          end
        end
      end
      default: begin
        if (w.query_index >= mesh_count) res.status = STS_BAD_INDEX;
        else begin
          sx = acc_x[w.query_index]; sy = acc_y[w.query_index]; sz = acc_z[w.query_index];
          mx = sx; my = sy; mz = sz;
          if (sx < 0) mx = -mx;
          if (sy < 0) my = -my;
          if (sz < 0) mz = -mz;
          mm = mx;
          if (my > mm) mm = my;
          if (mz > mm) mm = mz;
          if (mm == 0) res.status = STS_ZERO;
          else begin
            // Bring the largest magnitude into [2^30, 2^31)
            while (mm >= 64'h80000000) begin
              mm >>= 1; mx >>= 1; my >>= 1; mz >>= 1;
            end
            while (mm < 64'h40000000) begin
              mm <<= 1; mx <<= 1; my <<= 1; mz <<= 1;
            end
            sq = mx * mx + my * my + mz * mz;
            root = 0;
            bitv = 64'h1 << 62;
            while (bitv > sq) bitv >>= 2;
            while (bitv != 0) begin
              if (sq >= root + bitv) begin
                sq -= root + bitv;
                root = (root >> 1) + bitv;
              end else root >>= 1;
              bitv >>= 2;
            end
            res.normal_x = unit_q15(mx, root, sx < 0);
            res.normal_y = unit_q15(my, root, sy < 0);
            res.normal_z = unit_q15(mz, root, sz < 0);
          end
        end
      end
    endcase
    res.vertex_count = mesh_count[CNT_W-1:0];
    return res;
  endfunction

  // Predict on accept, check each strobed word against the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    taken = 1'b0;
    if (rst_n) begin
      quiet_cycles++;
      if (start && !busy) begin
        taken = 1'b1;
        expected_words.push_back(predict_normal(in_word));
        quiet_cycles = 0;
      end
      if (out_valid) begin
        quiet_cycles = 0;
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing expected, actual %h", $time, out_word);
          n_fail++;
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          case (out_word.status)
            STS_OK: if (out_word.normal_x | out_word.normal_y | out_word.normal_z) n_read_ok++;
            STS_FULL: n_full++;
            STS_BAD_INDEX: n_bad++;
            default: n_zero++;
          endcase
          if (out_word.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_word.status);
            n_fail++;
          end
          if (out_word.normal_x !== want.normal_x) begin
            $display("%0t: normal_x expected %0d actual %0d", $time, want.normal_x,
                     out_word.normal_x);
            n_fail++;
          end
          if (out_word.normal_y !== want.normal_y) begin
            $display("%0t: normal_y expected %0d actual %0d", $time, want.normal_y,
                     out_word.normal_y);
            n_fail++;
          end
          if (out_word.normal_z !== want.normal_z) begin
            $display("%0t: normal_z expected %0d actual %0d", $time, want.normal_z,
                     out_word.normal_z);
            n_fail++;
          end
          if (out_word.vertex_count !== want.vertex_count) begin
            $display("%0t: vertex_count expected %0d actual %0d", $time,
                     want.vertex_count, out_word.vertex_count);
            n_fail++;
          end
        end
      end
      if (quiet_cycles >= 4000) begin
        $display("%0t: timeout, no word moved for %0d cycles", $time, quiet_cycles);
        $display("** vertex_normal_accumulator_unit: FAILED **");
        $finish;
      end
    end
  end

  // Present the next pending word, idling at random
  always @(negedge clk) begin
    if (rst_n && (!start || taken)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_word <= pending_words.pop_front();
        start <= 1'b1;
        words_sent++;
      end else start <= 1'b0;
    end
  end

  function automatic in_word_t noise_word(cmd_t c);
    logic [127:0] raw;
    in_word_t     w;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    w = raw[$bits(in_word_t)-1:0];
    w.cmd = c;
    return w;
  endfunction

  // Track the vertex count the stimulus will produce
  task automatic queue_word(in_word_t w);
    if (w.cmd == CMD_CLEAR) gen_count = 0;
    else if (w.cmd == CMD_LOAD && gen_count < MAX_VERTICES) gen_count++;
    pending_words.push_back(w);
  endtask

  task automatic queue_load(int x, int y, int z);
    in_word_t w;
    w = noise_word(CMD_LOAD);
    w.coord_x = COORD_W'(x); w.coord_y = COORD_W'(y); w.coord_z = COORD_W'(z);
    queue_word(w);
  endtask

  task automatic queue_tri(int a, int b, int c);
    in_word_t w;
    w = noise_word(CMD_TRI);
    w.corner_a = IDX_W'(a); w.corner_b = IDX_W'(b); w.corner_c = IDX_W'(c);
    queue_word(w);
  endtask

  task automatic queue_read(int q);
    in_word_t w;
    w = noise_word(CMD_READ);
    w.query_index = IDX_W'(q);
    queue_word(w);
  endtask

  function automatic int pick_corner();
    if (gen_count == 0 || $urandom_range(99) < 10) return $urandom_range(4095);
    return $urandom_range(gen_count - 1);
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(5))
      0: return -8388608;
      1: return 8388607;
      2, 3: return $urandom_range(2000) - 1000;
      default: return int'($urandom_range(16777215)) - 8388608;
    endcase
  endfunction

  task automatic queue_random(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 2) queue_word(noise_word(CMD_CLEAR));
      else if (r < 32 || gen_count < 3) queue_load(pick_coord(), pick_coord(), pick_coord());
      else if (r < 72) queue_tri(pick_corner(), pick_corner(), pick_corner());
      else queue_read(pick_corner());
    end
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || start || expected_words.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: extremes, bad indices, repeated corner, zero-length normal
    queue_word(noise_word(CMD_CLEAR));
    queue_read(0);
    queue_tri(0, 1, 2);
    queue_load(-8388608, -8388608, -8388608);
    queue_load(8388607, 8388607, 8388607);
    queue_load(8388607, -8388608, 0);
    queue_load(0, 0, 0);
    queue_load(-8388608, 8388607, 8388607);
    queue_read(4);
    queue_tri(0, 2, 4);
    queue_tri(1, 3, 4);
    queue_tri(0, 2, 0);
    queue_tri(0, 1, 3);
    queue_tri(4095, 0, 1);
    queue_read(0);
    queue_read(1);
    queue_read(2);
    queue_read(3);
    queue_read(4);
    queue_read(4095);
    queue_read(5);
    queue_random(210);
    drain();

    idle_pct = 60;
    queue_random(230);
    drain();

    idle_pct = 0;
    queue_random(230);
    drain();

    repeat (200) @(posedge clk);
    $display("Sent %0d words, checked %0d results: %0d nonzero normals, %0d zero-length,",
             words_sent, words_checked, n_read_ok, n_zero);
    $display("%0d bad-index and %0d store-full results over three sender idle rates.",
             n_bad, n_full);
    if (n_fail == 0 && expected_words.size() == 0) begin
      $display("** vertex_normal_accumulator_unit: PASSED **");
    end else begin
      $display("** vertex_normal_accumulator_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/vna_pkg.sv
rtl/vertex_normal_accumulator_unit.sv
tb/vertex_normal_accumulator_unit_tb.sv
